FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Implication check: antecedent implies consequent on the same edge.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

FILE: design/crcfr_pkg.sv
`default_nettype none

package crcfr_pkg;

  localparam int unsigned NumWords  = 6;
  localparam logic [4:0]  FirstData = 5'd1;
  localparam logic [4:0]  LastData  = 5'd24;
  localparam logic [4:0]  CrcHiPos  = 5'd25;
  localparam logic [4:0]  CrcLoPos  = 5'd26;
  localparam logic [4:0]  LastPos   = 5'd27;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [7:0]  HeaderRst = 8'h4A;

  typedef enum logic {
    CfgHeader  = 1'b0,
    CfgEnforce = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [NumWords-1:0][31:0] words;
    logic [15:0]               frame_crc;
    logic                      crc_ok;
  } res_t;

  // CRC-16/Modbus, one byte, reflected.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/crcfr_rx_if.sv
`default_nettype none

interface crcfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: design/crcfr_res_if.sv
`default_nettype none

interface crcfr_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] word0;
  logic [31:0] word1;
  logic [31:0] word2;
  logic [31:0] word3;
  logic [31:0] word4;
  logic [31:0] word5;
  logic [15:0] frame_crc;
  logic        crc_ok;

  modport source (output valid, output word0, output word1, output word2, output word3,
                  output word4, output word5, output frame_crc, output crc_ok,
                  input ready);
  modport sink   (input valid, input word0, input word1, input word2, input word3,
                  input word4, input word5, input frame_crc, input crc_ok,
                  output ready);
endinterface

`default_nettype wire

FILE: design/crc16_frame_receiver.sv
// A result is registered: the frame's last byte passes the byte register, then the output register.
// Throughput: one byte per cycle sustained; the byte register stalls only while a
// finished result waits in the output register and is not taken.
// CRC-16/Modbus is a single unrolled byte step between byte register and state.
// Reset (async, active low): idle awaiting header 0x4A, enforcement off, no result
// pending; payload words and received CRC are undefined until a frame writes them.
`default_nettype none

`include "assert_macros.svh"

module crc16_frame_receiver
  import crcfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i,
  crcfr_rx_if.sink         rx_i,
  crcfr_res_if.source      res_o
);

  logic [7:0]  header_q;
  logic        enforce_q;

  logic        rx_vld_q;
  logic [7:0]  rx_byte_q;

  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [NumWords-1:0][31:0] word_q, word_d;
  logic [15:0] rcrc_q, rcrc_d;

  logic        res_vld_q, res_vld_d;
  res_t        res_q, res_d;

  logic        res_free;
  logic        proc;
  logic [4:0]  cnt_m1;
  logic [2:0]  widx;
  logic        ok;

  assign res_free    = !res_vld_q || res_o.ready;
  assign rx_i.ready  = !rx_vld_q || res_free;
  assign proc        = rx_vld_q && res_free;
  assign cnt_m1      = cnt_q - 5'd1;
  assign widx        = cnt_m1[4:2];
  assign ok          = (crc_q == rcrc_q);

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= HeaderRst;
      enforce_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgHeader:  header_q  <= cfg_wdata_i;
        CfgEnforce: enforce_q <= cfg_wdata_i[0];
        default:    ;
      endcase
    end
  end

  // byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      rx_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      rx_byte_q <= rx_i.rx_byte;
    end
  end

  // frame state and result
  always_comb begin
    cnt_d     = cnt_q;
    crc_d     = crc_q;
    word_d    = word_q;
    rcrc_d    = rcrc_q;
    res_vld_d = res_vld_q && !res_o.ready;
    res_d     = res_q;
    if (proc) begin
      if (cnt_q == 5'd0) begin
        if (rx_byte_q == header_q) begin
          crc_d = crc_step(CrcInit, rx_byte_q);
          cnt_d = FirstData;
        end
      end else if (cnt_q <= LastData) begin
        for (int k = 0; k < NumWords; k++) begin
          if (widx == 3'(k)) begin
            word_d[k] = {rx_byte_q, word_q[k][31:8]};
          end
        end
        crc_d = crc_step(crc_q, rx_byte_q);
        cnt_d = cnt_q + 5'd1;
      end else if (cnt_q == CrcHiPos) begin
        rcrc_d[15:8] = rx_byte_q;
        cnt_d        = cnt_q + 5'd1;
      end else if (cnt_q == CrcLoPos) begin
        rcrc_d[7:0] = rx_byte_q;
        cnt_d       = cnt_q + 5'd1;
      end else begin
        cnt_d = 5'd0;
        crc_d = CrcInit;
        if (!enforce_q || ok) begin
          res_vld_d       = 1'b1;
          res_d.words     = word_q;
          res_d.frame_crc = rcrc_q;
          res_d.crc_ok    = ok;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= 5'd0;
      crc_q     <= CrcInit;
      res_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      crc_q     <= crc_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    rcrc_q <= rcrc_d;
    res_q  <= res_d;
  end

  assign res_o.valid     = res_vld_q;
  assign res_o.word0     = res_q.words[0];
  assign res_o.word1     = res_q.words[1];
  assign res_o.word2     = res_q.words[2];
  assign res_o.word3     = res_q.words[3];
  assign res_o.word4     = res_q.words[4];
  assign res_o.word5     = res_q.words[5];
  assign res_o.frame_crc = res_q.frame_crc;
  assign res_o.crc_ok    = res_q.crc_ok;

  `ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= LastPos)
  `ASSERT_CLK(a_frame_end, clk_i, rst_ni, (proc && cnt_q == LastPos) |=> (cnt_q == 5'd0))
  `ASSERT_IMPL(a_enforce_ok, clk_i, rst_ni, res_vld_q && enforce_q, res_q.crc_ok)
  `ASSERT_CLK(a_byte_hold, clk_i, rst_ni,
              (rx_vld_q && !res_free) |=> (rx_vld_q && $stable(rx_byte_q)))

endmodule

`default_nettype wire

FILE: sim/crcfr_frame_checker.sv
`default_nettype none

module crcfr_frame_checker
  import crcfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i,
  crcfr_rx_if              rx_i,
  crcfr_res_if             res_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [4:0]  frame_pos;
  logic [15:0] crc_run;
  logic [31:0] payload_acc [NumWords];
  logic [15:0] crc_field;
  logic [7:0]  hdr_cfg;
  logic        enforce_cfg;

  res_t        expected_frames [$];
  res_t        got_frame;
  res_t        want_frame;
  int unsigned mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic logic [15:0] crc16_modbus(input logic [15:0] seed, input logic [7:0] b);
    logic [15:0] c;
    c = seed ^ {8'h00, b};
    repeat (8) begin
      c = c[0] ? ({1'b0, c[15:1]} ^ CrcPoly) : {1'b0, c[15:1]};
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Deframer model: one received byte per call.
  task automatic absorb_byte(input logic [7:0] b);
    int   w;
    logic match;
    res_t exp_frame;
    if (frame_pos == 5'd0) begin
      if (b == hdr_cfg) begin
        crc_run   = crc16_modbus(CrcInit, b);
        frame_pos = FirstData;
      end
    end else if (frame_pos <= LastData) begin
      w = (frame_pos - 1) >> 2;
      payload_acc[w] = {b, payload_acc[w][31:8]};
      crc_run   = crc16_modbus(crc_run, b);
      frame_pos = frame_pos + 5'd1;
    end else if (frame_pos == CrcHiPos) begin
      crc_field[15:8] = b;
      frame_pos       = frame_pos + 5'd1;
    end else if (frame_pos == CrcLoPos) begin
      crc_field[7:0] = b;
      frame_pos      = frame_pos + 5'd1;
    end else begin
      frame_pos = 5'd0;
      match     = (crc_run == crc_field);
      crc_run   = CrcInit;
      if (!(enforce_cfg && !match)) begin
        for (int k = 0; k < NumWords; k++) begin
          exp_frame.words[k] = payload_acc[k];
        end
        exp_frame.frame_crc = crc_field;
        exp_frame.crc_ok    = match;
        expected_frames = {expected_frames, exp_frame};
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pos   = 5'd0;
      crc_run     = CrcInit;
      crc_field   = 16'h0000;
      hdr_cfg     = HeaderRst;
      enforce_cfg = 1'b0;
      for (int k = 0; k < NumWords; k++) begin
        payload_acc[k] = 32'h0;
      end
      expected_frames.delete();
      pending_o <= 0;
    end else begin
      if (rx_i.valid && rx_i.ready) begin
        absorb_byte(rx_i.rx_byte);
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgHeader:  hdr_cfg = cfg_wdata_i;
          CfgEnforce: enforce_cfg = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (res_i.valid && res_i.ready) begin
        got_frame.words[0]  = res_i.word0;
        got_frame.words[1]  = res_i.word1;
        got_frame.words[2]  = res_i.word2;
        got_frame.words[3]  = res_i.word3;
        got_frame.words[4]  = res_i.word4;
        got_frame.words[5]  = res_i.word5;
        got_frame.frame_crc = res_i.frame_crc;
        got_frame.crc_ok    = res_i.crc_ok;
        if (expected_frames.size() == 0) begin
          report_mismatch($sformatf("frame result with none expected, word0=%h crc=%h",
                                    got_frame.words[0], got_frame.frame_crc));
        end else begin
          want_frame = expected_frames.pop_front();
          for (int k = 0; k < NumWords; k++) begin
            if (got_frame.words[k] !== want_frame.words[k]) begin
              report_mismatch($sformatf("word%0d got %h want %h", k,
                                        got_frame.words[k], want_frame.words[k]));
            end
          end
          if (got_frame.frame_crc !== want_frame.frame_crc) begin
            report_mismatch($sformatf("frame_crc got %h want %h",
                                      got_frame.frame_crc, want_frame.frame_crc));
          end
          if (got_frame.crc_ok !== want_frame.crc_ok) begin
            report_mismatch($sformatf("crc_ok got %b want %b",
                                      got_frame.crc_ok, want_frame.crc_ok));
          end
        end
      end
      pending_o <= expected_frames.size();
    end
  end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`default_nettype none

module testbench
  import crcfr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  typedef enum int {FillRandom, FillZero, FillOnes, FillHeader} fill_e;
  typedef enum int {FrameGood, FrameBadCrc} frame_kind_e;
  typedef enum int {RdyAlways, RdyCoin, RdyEveryFourth, RdySparse} stall_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_wdata_i;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  int          burst_left = 0;
  int unsigned frame_bytes = 0;
  bit          press_req = 1'b0;
  logic [7:0]  rand_hdr;

  crcfr_rx_if  rx_if ();
  crcfr_res_if res_if ();

  crc16_frame_receiver DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  crcfr_frame_checker frame_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rx_i         (rx_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: stall patterns in segments, plus one long hold on request.
  initial begin : res_side
    int          seg;
    stall_mode_e mode;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (press_req) begin
        press_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat ($urandom_range(300, 400)) @(posedge clk_i);
      end
      seg  = $urandom_range(10, 100);
      mode = stall_mode_e'($urandom_range(0, 3));
      for (int k = 0; k < seg; k++) begin
        case (mode)
          RdyAlways:      res_if.ready <= 1'b1;
          RdyCoin:        res_if.ready <= 1'($urandom_range(0, 1));
          RdyEveryFourth: res_if.ready <= (k % 4 == 0);
          default:        res_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic send_frame(input logic [7:0] hdr, input fill_e fill, input frame_kind_e kind);
    logic [7:0]  frm [28];
    logic [15:0] crc;
    frm[0] = hdr;
    crc    = crcfr_pkg::crc_step(CrcInit, hdr);
    for (int i = 1; i <= 24; i++) begin
      case (fill)
        FillZero:   frm[i] = 8'h00;
        FillOnes:   frm[i] = 8'hFF;
        FillHeader: frm[i] = hdr;
        default:    frm[i] = 8'($urandom);
      endcase
      crc = crcfr_pkg::crc_step(crc, frm[i]);
    end
    if (kind == FrameBadCrc) begin
      crc ^= 16'(1 << $urandom_range(0, 15));
    end
    frm[25] = crc[15:8];
    frm[26] = crc[7:0];
    frm[27] = 8'($urandom);
    for (int i = 0; i < 28; i++) begin
      send_byte(frm[i]);
    end
    frame_bytes += 28;
  endtask

  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [7:0] hdr, input logic enforce);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgHeader;
    cfg_wdata_i <= hdr;
    @(posedge clk_i);
    cfg_idx_i   <= CfgEnforce;
    cfg_wdata_i <= {7'b0, enforce};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed frames; some truncated frames and line noise.
  task automatic random_phase(input logic [7:0] hdr, input int unsigned nbytes);
    int unsigned stop_at;
    int          r;
    int          n;
    stop_at = frame_bytes + nbytes;
    while (frame_bytes < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_frame(hdr, ($urandom_range(0, 9) == 0) ? FillHeader : FillRandom,
                   ($urandom_range(0, 4) == 0) ? FrameBadCrc : FrameGood);
      end else if (r < 85) begin
        n = $urandom_range(1, 26);
        send_byte(hdr);
        repeat (n) send_byte(8'($urandom));
        frame_bytes += n + 1;
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgHeader;
    cfg_wdata_i   <= 8'h00;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: noise is dropped, frames delivered with flag
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HeaderRst ^ 8'h01);
    send_frame(HeaderRst, FillZero, FrameGood);
    send_frame(HeaderRst, FillOnes, FrameGood);
    send_frame(HeaderRst, FillHeader, FrameBadCrc);
    send_frame(HeaderRst, FillRandom, FrameGood);

    // enforcement: bad frame dropped, next one still framed correctly
    write_settings(HeaderRst, 1'b1);
    send_frame(HeaderRst, FillRandom, FrameBadCrc);
    send_frame(HeaderRst, FillOnes, FrameGood);

    write_settings(8'h00, 1'b0);
    press_req = 1'b1;
    random_phase(8'h00, 160);
    write_settings(8'hFF, 1'b1);
    random_phase(8'hFF, 160);
    write_settings(HeaderRst, 1'b0);
    random_phase(HeaderRst, 160);
    rand_hdr = 8'($urandom_range(1, 254));
    write_settings(rand_hdr, 1'b1);
    random_phase(rand_hdr, 160);
    rand_hdr = 8'($urandom_range(1, 254));
    write_settings(rand_hdr, 1'b0);
    random_phase(rand_hdr, 160);
    write_settings(HeaderRst, 1'b1);
    random_phase(HeaderRst, 160);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
